>>> design/nps_pkg.sv
// ============================================================================
// nps_pkg
// Shared constants and types for the nearest point search unit.
// ============================================================================
package nps_pkg;

    // Store geometry
    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;

    // Coordinate and distance widths
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int NEAR_IDX_W = 10;

    // Operation codes carried on the input tuser
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // One stored point read back from the store, tagged with its position
    typedef struct packed {
        logic                      vld;
        logic [ADDR_W-1:0]         idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_pt_req;

    // Same point with its squared axis distances to the query position
    typedef struct packed {
        logic                      vld;
        logic [ADDR_W-1:0]         idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SQ_W-1:0]           sqx;
        logic [SQ_W-1:0]           sqy;
    } t_pt_rsp;

endpackage

>>> design/nearest_point_search_unit.sv
// ============================================================================
// nearest_point_search_unit
// Brute-force 2D nearest neighbor over a store of appended points.
// ============================================================================
//
// Channel   Dir  Handshake               Payload
// --------  ---  ----------------------  ----------------------------------
// s_axis    in   s_axis_tvalid/tready    tuser: op; tdata: pos_x, pos_y
// m_axis    out  m_axis_tvalid/tready    tdata: near_x, near_y, near_index;
//                                        tuser: found
//
// Clear and append complete as they are accepted. A query holds
// s_axis_tready low while the stored points are scanned and the distance
// pipe drains: the single read port of the point store delivers one
// stored point per cycle into the distance pipe.
// Reset (synchronous, active low) empties the store and idles the unit.
// A query whose result cannot leave because m_axis is stalled holds in
// its final state; the output register lets one earlier result wait
// while a new request is taken.
// ============================================================================
module nearest_point_search_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] pos_x, [31:16] pos_y
    input  logic [1:0]  s_axis_tuser,  // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [15:0] near_x, [31:16] near_y,
                                       // [41:32] near_index, [47:42] zero
    output logic [0:0]  m_axis_tuser   // [0] found
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    localparam int CW = nps_pkg::COORD_W;
    localparam int AW = nps_pkg::ADDR_W;
    localparam int NW = nps_pkg::CNT_W;

    // Control state
    logic [1:0]     r_state,   n_state;
    logic [NW-1:0]  r_count,   n_count;
    logic [NW-1:0]  r_rd_addr, n_rd_addr;
    logic           r_m_valid;

    // Point store: one write port for appends, one read port for the scan
    logic [2*CW-1:0] r_mem [nps_pkg::MAX_POINTS];
    logic [2*CW-1:0] r_rd_data;
    logic            r_rd_vld;
    logic [AW-1:0]   r_rd_idx;

    // Query position and running best
    logic signed [CW-1:0]        r_qx;
    logic signed [CW-1:0]        r_qy;
    logic                        r_have;
    logic [nps_pkg::DIST_W-1:0]  r_best_d;
    logic [AW-1:0]               r_best_idx;
    logic signed [CW-1:0]        r_best_x;
    logic signed [CW-1:0]        r_best_y;

    // Result register
    logic signed [CW-1:0]            r_o_x;
    logic signed [CW-1:0]            r_o_y;
    logic [nps_pkg::NEAR_IDX_W-1:0]  r_o_idx;
    logic                            r_o_found;

    logic                        w_acc;
    logic                        w_issue;
    logic                        w_full;
    logic                        w_load;
    logic                        w_better;
    logic [nps_pkg::DIST_W-1:0]  w_dist;
    nps_pkg::t_pt_req            w_req;
    nps_pkg::t_pt_rsp            w_rsp;
    logic                        w_busy;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc   = s_axis_tvalid & s_axis_tready;
    assign w_full  = (r_count == NW'(nps_pkg::MAX_POINTS));
    assign w_issue = (r_state == ST_SCAN) && (r_rd_addr < r_count);
    assign w_load  = (r_state == ST_FIN) && (!r_m_valid || m_axis_tready);

    // Next-state and counters
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_addr = r_rd_addr;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (s_axis_tuser)
                        nps_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        nps_pkg::OP_APPEND: begin
                            if (!w_full) begin
                                n_count = r_count + NW'(1);
                            end
                        end
                        nps_pkg::OP_QUERY: begin
                            n_state   = ST_SCAN;
                            n_rd_addr = '0;
                        end
                        default: begin
                            // unused code: drop the request
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_issue) begin
                    n_rd_addr = r_rd_addr + NW'(1);
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait until the last point has been compared
                if (!r_rd_vld && !w_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_rd_addr <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_addr <= n_rd_addr;
        end
    end

    // Store write on append, registered read during the scan
    always_ff @(posedge i_clk) begin
        if (w_acc && (s_axis_tuser == nps_pkg::OP_APPEND) && !w_full) begin
            r_mem[r_count[AW-1:0]] <= s_axis_tdata;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_rd_addr[AW-1:0]];
        end
        r_rd_idx <= r_rd_addr[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
        end
    end

    // Capture the query position
    always_ff @(posedge i_clk) begin
        if (w_acc && (s_axis_tuser == nps_pkg::OP_QUERY)) begin
            r_qx <= s_axis_tdata[CW-1:0];
            r_qy <= s_axis_tdata[2*CW-1:CW];
        end
    end

    assign w_req.vld = r_rd_vld;
    assign w_req.idx = r_rd_idx;
    assign w_req.x   = r_rd_data[CW-1:0];
    assign w_req.y   = r_rd_data[2*CW-1:CW];

    nps_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_req   (w_req),
        .o_rsp   (w_rsp),
        .o_busy  (w_busy)
    );

    // Keep the best; only a strictly smaller distance replaces it, so the
    // earliest point wins a tie
    assign w_dist   = nps_pkg::DIST_W'(w_rsp.sqx) + nps_pkg::DIST_W'(w_rsp.sqy);
    assign w_better = !r_have || (w_dist < r_best_d);

    always_ff @(posedge i_clk) begin
        if (w_rsp.vld && w_better) begin
            r_best_d   <= w_dist;
            r_best_idx <= w_rsp.idx;
            r_best_x   <= w_rsp.x;
            r_best_y   <= w_rsp.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (w_acc && (s_axis_tuser == nps_pkg::OP_QUERY)) begin
            r_have <= 1'b0;
        end else if (w_rsp.vld) begin
            r_have <= 1'b1;
        end
    end

    // Result register: an empty store reports zeros with found low
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_found <= r_have;
            r_o_x     <= r_have ? r_best_x : '0;
            r_o_y     <= r_have ? r_best_y : '0;
            r_o_idx   <= r_have ? r_best_idx[nps_pkg::NEAR_IDX_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = {6'd0, r_o_idx, r_o_y, r_o_x};
    assign m_axis_tuser[0] = r_o_found;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!r_rd_vld && !w_busy))
        else $error("distance pipe active while taking requests");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(nps_pkg::MAX_POINTS))
        else $error("point count above capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_rd_addr <= r_count))
        else $error("scan address past point count");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_o_found) |-> (r_o_idx == '0 && r_o_x == '0 && r_o_y == '0))
        else $error("empty-store result carries nonzero fields");

endmodule

>>> design/nps_dist.sv
// ============================================================================
// nps_dist
// Two-stage squared axis distance pipe: difference, then square.
// ============================================================================
module nps_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [nps_pkg::COORD_W-1:0] i_qx,
    input  logic signed [nps_pkg::COORD_W-1:0] i_qy,
    input  nps_pkg::t_pt_req                  i_req,
    output nps_pkg::t_pt_rsp                  o_rsp,
    output logic                              o_busy
);

    nps_pkg::t_pt_req                         r_s1;
    logic signed [nps_pkg::DIFF_W-1:0]        r_dx;
    logic signed [nps_pkg::DIFF_W-1:0]        r_dy;
    nps_pkg::t_pt_rsp                         r_s2;

    logic signed [nps_pkg::DIFF_W-1:0]        n_dx;
    logic signed [nps_pkg::DIFF_W-1:0]        n_dy;
    logic signed [nps_pkg::PROD_W-1:0]        n_px;
    logic signed [nps_pkg::PROD_W-1:0]        n_py;

    // Stage 1: sign-extend and subtract
    assign n_dx = nps_pkg::DIFF_W'(i_req.x) - nps_pkg::DIFF_W'(i_qx);
    assign n_dy = nps_pkg::DIFF_W'(i_req.y) - nps_pkg::DIFF_W'(i_qy);

    // Stage 2: square; the result is never negative and fits SQ_W bits
    assign n_px = nps_pkg::PROD_W'(r_dx) * nps_pkg::PROD_W'(r_dx);
    assign n_py = nps_pkg::PROD_W'(r_dy) * nps_pkg::PROD_W'(r_dy);

    always_ff @(posedge i_clk) begin
        r_s1.idx <= i_req.idx;
        r_s1.x   <= i_req.x;
        r_s1.y   <= i_req.y;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_s2.idx <= r_s1.idx;
        r_s2.x   <= r_s1.x;
        r_s2.y   <= r_s1.y;
        r_s2.sqx <= n_px[nps_pkg::SQ_W-1:0];
        r_s2.sqy <= n_py[nps_pkg::SQ_W-1:0];
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
        end else begin
            r_s1.vld <= i_req.vld;
            r_s2.vld <= r_s1.vld;
        end
    end

    assign o_rsp  = r_s2;
    assign o_busy = r_s1.vld | r_s2.vld;

endmodule
